### rtl/ufr_pkg.sv
// Shared types and constants for the framed byte receiver.
package ufr_pkg;

	localparam int CfgIndexWidth = 2;

	localparam logic [CfgIndexWidth-1:0] CFG_SYNC_FIRST   = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_SYNC_SECOND  = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_LENGTH_LIMIT = 2'd2;

	localparam logic [7:0]  SYNC_FIRST_RESET   = 8'd181;
	localparam logic [7:0]  SYNC_SECOND_RESET  = 8'd98;
	localparam logic [15:0] LENGTH_LIMIT_RESET = 16'd257;

	localparam logic FUNC_PARSE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_GOOD     = 3'd1;
	localparam logic [2:0] ST_BAD_SYNC = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_OVERRUN  = 3'd4;
	localparam logic [2:0] ST_BAD_CKA  = 3'd5;
	localparam logic [2:0] ST_BAD_CKB  = 3'd6;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic [7:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic        frame_ok;
		logic [2:0]  status;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
		logic [15:0] frame_length;
		logic [7:0]  read_data;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] length_limit;
	} cfg_t;

	typedef struct packed {
		logic        frame_ok;
		logic [2:0]  status;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
		logic [15:0] frame_length;
	} parse_res_t;

endpackage

### rtl/ufr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ufr_parser.sv
// Frame recognizer: phase sequencer, header registers, checksum and payload write control.
module ufr_parser #(
	parameter int PAYLOAD_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  ufr_pkg::in_item_t                item,
	input  ufr_pkg::cfg_t                    cfg,
	output ufr_pkg::parse_res_t              res,
	output logic                             wr_en,
	output logic [$clog2(PAYLOAD_DEPTH)-1:0] wr_addr,
	output logic [7:0]                       wr_data
);
	import ufr_pkg::*;

	localparam int AW = $clog2(PAYLOAD_DEPTH);
	localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
	localparam int LW = (CW > 16) ? CW : 16;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_SYNC1   = 4'd1,
		PH_SYNC2   = 4'd2,
		PH_CLASS   = 4'd3,
		PH_ID      = 4'd4,
		PH_LEN1    = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CKA     = 4'd7,
		PH_CKB     = 4'd8
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [7:0]    class_q, class_d;
	logic [7:0]    id_q, id_d;
	logic [15:0]   length_q, length_d;
	logic [7:0]    sum_a_q, sum_a_d;
	logic [7:0]    sum_b_q, sum_b_d;
	logic [CW-1:0] count_q, count_d;

	logic [7:0]    b;
	logic [7:0]    add_a;
	logic [7:0]    add_b;
	logic [15:0]   len_new;
	logic [CW-1:0] count_inc;
	logic          ok;
	logic [2:0]    status;

	assign b         = item.data_byte;
	assign add_a     = sum_a_q + b;
	assign add_b     = sum_b_q + add_a;
	assign len_new   = {b, length_q[7:0]};
	assign count_inc = count_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		class_d  = class_q;
		id_d     = id_q;
		length_d = length_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		count_d  = count_q;
		ok       = 1'b0;
		status   = ST_NONE;
		wr_en    = 1'b0;
		if (item.func == FUNC_PARSE) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (b == cfg.sync_first) begin
						phase_d = PH_SYNC1;
					end
				end
				PH_SYNC1: begin
					if (b == cfg.sync_second) begin
						phase_d = PH_SYNC2;
						sum_a_d = '0;
						sum_b_d = '0;
					end else begin
						phase_d = PH_IDLE;
						status  = ST_BAD_SYNC;
					end
				end
				PH_SYNC2: begin
					class_d = b;
					sum_a_d = add_a;
					sum_b_d = add_b;
					phase_d = PH_CLASS;
				end
				PH_CLASS: begin
					id_d    = b;
					sum_a_d = add_a;
					sum_b_d = add_b;
					phase_d = PH_ID;
				end
				PH_ID: begin
					length_d = {8'd0, b};
					sum_a_d  = add_a;
					sum_b_d  = add_b;
					phase_d  = PH_LEN1;
				end
				PH_LEN1: begin
					length_d = len_new;
					if (len_new < cfg.length_limit) begin
						sum_a_d = add_a;
						sum_b_d = add_b;
						count_d = '0;
						phase_d = (len_new == 16'd0) ? PH_CKA : PH_PAYLOAD;
					end else begin
						phase_d = PH_IDLE;
						status  = ST_TOO_LONG;
					end
				end
				PH_PAYLOAD: begin
					if (count_q < CW'(PAYLOAD_DEPTH)) begin
						sum_a_d = add_a;
						sum_b_d = add_b;
						wr_en   = 1'b1;
						count_d = count_inc;
						if (LW'(count_inc) == LW'(length_q)) begin
							phase_d = PH_CKA;
						end
					end else begin
						// store full: drop the byte
						phase_d = PH_IDLE;
						status  = ST_OVERRUN;
					end
				end
				PH_CKA: begin
					if (b == sum_a_q) begin
						phase_d = PH_CKB;
					end else begin
						phase_d = PH_IDLE;
						status  = ST_BAD_CKA;
					end
				end
				PH_CKB: begin
					phase_d = PH_IDLE;
					if (b == sum_b_q) begin
						ok     = 1'b1;
						status = ST_GOOD;
					end else begin
						status = ST_BAD_CKB;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	assign wr_addr = count_q[AW-1:0];
	assign wr_data = b;

	assign res.frame_ok     = ok;
	assign res.status       = status;
	assign res.frame_class  = class_d;
	assign res.frame_id     = id_d;
	assign res.frame_length = length_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			class_q  <= '0;
			id_q     <= '0;
			length_q <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			count_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			class_q  <= class_d;
			id_q     <= id_d;
			length_q <= length_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
			count_q  <= count_d;
		end
	end

endmodule

### rtl/ubx_frame_receiver_core.sv
// Top level of the framed byte receiver: configuration, payload RAM and result pipeline.
//
// Items arrive on the item channel (valid/ready). A parse item (func 0) feeds one link
// byte to the frame recognizer; a read item (func 1) fetches one stored payload byte.
// Every item yields exactly one result on the result channel, in order.
// Configuration registers are written through the cfg channel, which is always ready;
// write them only while no item is in flight.
// Pipeline: stage 1 catches the RAM read data at the item transfer, stage 2 is the
// output register; result valid rises once stage 2 holds the item's result.
// Throughput: one item per cycle while results are taken; the recognizer updates its
// state in the cycle of the transfer and the RAM takes one write or one read per item.
// When the result receiver stalls, the output register holds its result and the RAM
// stage holds one more, so one further item is taken before item ready drops.
// Reset clears the recognizer to waiting for the first sync byte, zeroes the header
// and checksum registers, restores the register defaults and empties the pipeline.
// The payload RAM is not cleared; reading an entry never written returns garbage.
module ubx_frame_receiver_core #(
	parameter int PAYLOAD_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  ufr_pkg::in_item_t               item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output ufr_pkg::out_item_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ufr_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [15:0]                     cfg_data
);
	import ufr_pkg::*;

	localparam int AW = $clog2(PAYLOAD_DEPTH);

	cfg_t       cfg_q;
	parse_res_t res;
	logic       accept;
	logic       wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic       rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0] rd_data;
	logic       rd_in_range;

	logic       valid_s1;
	parse_res_t res_s1;
	logic       rd_s1;
	logic       valid_s2;
	out_item_t  out_s2;
	logic       advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first   <= SYNC_FIRST_RESET;
			cfg_q.sync_second  <= SYNC_SECOND_RESET;
			cfg_q.length_limit <= LENGTH_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:   cfg_q.sync_first   <= cfg_data[7:0];
				CFG_SYNC_SECOND:  cfg_q.sync_second  <= cfg_data[7:0];
				CFG_LENGTH_LIMIT: cfg_q.length_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign accept     = item_valid && item_ready;

	ufr_parser #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.cfg     (cfg_q),
		.res     (res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign rd_in_range = {24'd0, item.read_index} < 32'(PAYLOAD_DEPTH);
	assign rd_en       = accept && (item.func == FUNC_READ);
	assign rd_addr     = AW'(item.read_index);

	ufr_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_payload_ram (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// stage 1 waits for RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			rd_s1  <= (item.func == FUNC_READ) && rd_in_range;
		end
	end

	// stage 2 is the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2.frame_ok     <= res_s1.frame_ok;
			out_s2.status       <= res_s1.status;
			out_s2.frame_class  <= res_s1.frame_class;
			out_s2.frame_id     <= res_s1.frame_id;
			out_s2.frame_length <= res_s1.frame_length;
			out_s2.read_data    <= rd_s1 ? rd_data : 8'd0;
		end
	end

	assign result_valid = valid_s2;
	assign result       = out_s2;

endmodule

### sim/testbench.sv
// Self-checking testbench for the framed byte receiver: directed and random traffic, in-order result scoreboard.
module testbench;
	import ufr_pkg::*;

	localparam int STORE_DEPTH  = 256;
	localparam int LONG_STALL   = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 140;

	localparam logic [CfgIndexWidth-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [3:0] {
		RX_HUNT, RX_SYNC1, RX_SYNC2, RX_CLASS, RX_ID, RX_LEN_LO, RX_PAYLOAD, RX_CKA, RX_CKB
	} rx_phase_t;

	typedef enum logic [1:0] {FAULT_NONE, FAULT_SYNC2, FAULT_CKA, FAULT_CKB} frame_fault_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ubx_frame_receiver_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver model state and its copy of the registers
	logic [7:0]  cfg_sync1 = SYNC_FIRST_RESET;
	logic [7:0]  cfg_sync2 = SYNC_SECOND_RESET;
	logic [15:0] cfg_limit = LENGTH_LIMIT_RESET;
	rx_phase_t   rx_phase = RX_HUNT;
	logic [7:0]  rx_class = '0;
	logic [7:0]  rx_id = '0;
	logic [15:0] rx_length = '0;
	logic [7:0]  rx_sum_a = '0;
	logic [7:0]  rx_sum_b = '0;
	int          rx_count = 0;
	logic [7:0]  rx_store [STORE_DEPTH];
	int          store_filled = 0;

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int queued_count = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 12;
	int recv_idle_pct = 77;
	int stall_requests = 0;
	int stall_served = 0;
	int stall_left = 0;
	logic item_taken = 1'b0;

	// sums = {sum_b, sum_a}
	function automatic logic [15:0] fletcher_next(input logic [15:0] sums, input logic [7:0] d);
		logic [7:0] a;
		logic [7:0] b;
		a = sums[7:0] + d;
		b = sums[15:8] + a;
		return {b, a};
	endfunction

	function automatic out_item_t rx_predict(input in_item_t it);
		out_item_t r;
		logic [7:0] d;
		r = '0;
		d = it.data_byte;
		if (it.func == FUNC_READ) begin
			r.read_data = rx_store[it.read_index];
		end else begin
			case (rx_phase)
				RX_HUNT: begin
					if (d == cfg_sync1)
						rx_phase = RX_SYNC1;
				end
				RX_SYNC1: begin
					if (d == cfg_sync2) begin
						rx_phase = RX_SYNC2;
						rx_sum_a = '0;
						rx_sum_b = '0;
					end else begin
						rx_phase = RX_HUNT;
						r.status = ST_BAD_SYNC;
					end
				end
				RX_SYNC2: begin
					rx_class = d;
					{rx_sum_b, rx_sum_a} = fletcher_next({rx_sum_b, rx_sum_a}, d);
					rx_phase = RX_CLASS;
				end
				RX_CLASS: begin
					rx_id = d;
					{rx_sum_b, rx_sum_a} = fletcher_next({rx_sum_b, rx_sum_a}, d);
					rx_phase = RX_ID;
				end
				RX_ID: begin
					rx_length = {8'h00, d};
					{rx_sum_b, rx_sum_a} = fletcher_next({rx_sum_b, rx_sum_a}, d);
					rx_phase = RX_LEN_LO;
				end
				RX_LEN_LO: begin
					rx_length = {d, rx_length[7:0]};
					if (rx_length < cfg_limit) begin
						{rx_sum_b, rx_sum_a} = fletcher_next({rx_sum_b, rx_sum_a}, d);
						rx_count = 0;
						rx_phase = (rx_length == 16'd0) ? RX_CKA : RX_PAYLOAD;
					end else begin
						rx_phase = RX_HUNT;
						r.status = ST_TOO_LONG;
					end
				end
				RX_PAYLOAD: begin
					if (rx_count < STORE_DEPTH) begin
						{rx_sum_b, rx_sum_a} = fletcher_next({rx_sum_b, rx_sum_a}, d);
						rx_store[rx_count] = d;
						rx_count++;
						if (rx_count > store_filled)
							store_filled = rx_count;
						if (rx_count == rx_length)
							rx_phase = RX_CKA;
					end else begin
						rx_phase = RX_HUNT;
						r.status = ST_OVERRUN;
					end
				end
				RX_CKA: begin
					if (d == rx_sum_a) begin
						rx_phase = RX_CKB;
					end else begin
						rx_phase = RX_HUNT;
						r.status = ST_BAD_CKA;
					end
				end
				RX_CKB: begin
					rx_phase = RX_HUNT;
					if (d == rx_sum_b) begin
						r.frame_ok = 1'b1;
						r.status = ST_GOOD;
					end else begin
						r.status = ST_BAD_CKB;
					end
				end
				default: rx_phase = RX_HUNT;
			endcase
		end
		r.frame_class = rx_class;
		r.frame_id = rx_id;
		r.frame_length = rx_length;
		return r;
	endfunction

	task automatic queue_item(input in_item_t it);
		pending_items.push_back(it);
		expected_results.push_back(rx_predict(it));
		queued_count++;
	endtask

	task automatic queue_byte(input logic [7:0] d);
		in_item_t it;
		it.func = FUNC_PARSE;
		it.data_byte = d;
		it.read_index = 8'($urandom);
		queue_item(it);
	endtask

	task automatic queue_read_at(input int idx);
		in_item_t it;
		it.func = FUNC_READ;
		it.data_byte = 8'($urandom);
		it.read_index = 8'(idx);
		queue_item(it);
	endtask

	// only entries already written by some payload are ever read
	task automatic queue_read_any();
		if (store_filled > 0)
			queue_read_at($urandom_range(0, store_filled - 1));
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
			input logic [15:0] len, input frame_fault_t fault, input int read_pct);
		logic [15:0] sums;
		logic [7:0]  flip;
		logic [7:0]  d;
		sums = '0;
		flip = 8'($urandom_range(1, 255));
		queue_byte(cfg_sync1);
		if (fault == FAULT_SYNC2) begin
			queue_byte(cfg_sync2 ^ flip);
			return;
		end
		queue_byte(cfg_sync2);
		queue_byte(cls);
		sums = fletcher_next(sums, cls);
		queue_byte(id);
		sums = fletcher_next(sums, id);
		queue_byte(len[7:0]);
		sums = fletcher_next(sums, len[7:0]);
		queue_byte(len[15:8]);
		if (len >= cfg_limit)
			return;
		sums = fletcher_next(sums, len[15:8]);
		for (int i = 0; i < len; i++) begin
			d = 8'($urandom);
			if ($urandom_range(0, 99) < read_pct)
				queue_read_any();
			queue_byte(d);
			// the byte past a full store aborts the frame
			if (i == STORE_DEPTH)
				return;
			sums = fletcher_next(sums, d);
		end
		if (fault == FAULT_CKA) begin
			queue_byte(sums[7:0] ^ flip);
			return;
		end
		queue_byte(sums[7:0]);
		queue_byte((fault == FAULT_CKB) ? (sums[15:8] ^ flip) : sums[15:8]);
	endtask

	task automatic send_random_frame();
		int roll;
		int cap;
		logic [15:0] len;
		frame_fault_t fault;
		roll = $urandom_range(0, 99);
		fault = (roll < 70) ? FAULT_NONE : (roll < 80) ? FAULT_SYNC2 :
			(roll < 90) ? FAULT_CKA : FAULT_CKB;
		roll = $urandom_range(0, 99);
		if (roll < 5 || cfg_limit == 16'd0) begin
			if (cfg_limit == 16'hFFFF)
				len = 16'hFFFF;
			else
				len = 16'(cfg_limit + $urandom_range(0, 16'hFFFF - cfg_limit));
		end else begin
			cap = (roll < 8) ? 300 : 16;
			if (cap > int'(cfg_limit) - 1)
				cap = int'(cfg_limit) - 1;
			len = 16'($urandom_range(0, cap));
		end
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
		if ($urandom_range(0, 99) < 10)
			queue_read_any();
		send_frame(8'($urandom), 8'($urandom), len, fault, 8);
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_SYNC_FIRST:   cfg_sync1 = data[7:0];
			CFG_SYNC_SECOND:  cfg_sync2 = data[7:0];
			CFG_LENGTH_LIMIT: cfg_limit = data;
			default: ;
		endcase
	endtask

	// upper data bits of the sync registers are random and must be ignored
	task automatic reconfigure(input logic [7:0] s1, input logic [7:0] s2, input logic [15:0] lim);
		logic [7:0] junk;
		junk = 8'($urandom);
		wait_drained();
		cfg_write(CFG_SYNC_FIRST, {junk, s1});
		cfg_write(CFG_SYNC_SECOND, {~junk, s2});
		cfg_write(CFG_LENGTH_LIMIT, lim);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// item driver
	always @(posedge clk)
		item_taken <= item_valid && item_ready;

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus requested long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_served != stall_requests) begin
			stall_served <= stall_served + 1;
			stall_left <= LONG_STALL;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: ok=%0d st=%0d cls=%02h id=%02h len=%04h rd=%02h",
						result.frame_ok, result.status, result.frame_class, result.frame_id,
						result.frame_length, result.read_data);
			end else begin
				want = expected_results.pop_front();
				if (result.frame_ok !== want.frame_ok || result.status !== want.status ||
						result.frame_class !== want.frame_class ||
						result.frame_id !== want.frame_id ||
						result.frame_length !== want.frame_length ||
						result.read_data !== want.read_data) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected ok=%0d st=%0d cls=%02h id=%02h len=%04h rd=%02h",
							want.frame_ok, want.status, want.frame_class, want.frame_id,
							want.frame_length, want.read_data);
						$display("          got      ok=%0d st=%0d cls=%02h id=%02h len=%04h rd=%02h",
							result.frame_ok, result.status, result.frame_class, result.frame_id,
							result.frame_length, result.read_data);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [7:0] same_sync;
		int phase_goal;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed frames at the reset register values
		queue_byte(8'h00);
		queue_byte(8'hFF);
		send_frame(8'h00, 8'hFF, 16'd2, FAULT_NONE, 0);
		queue_read_at(0);
		queue_read_at(1);
		send_frame(8'hFF, 8'h00, 16'd0, FAULT_NONE, 0);
		send_frame(8'h12, 8'h34, 16'd1, FAULT_SYNC2, 0);
		send_frame(8'h56, 8'h78, LENGTH_LIMIT_RESET, FAULT_NONE, 0);
		send_frame(8'h9A, 8'hBC, 16'hFFFF, FAULT_NONE, 0);
		send_frame(8'h01, 8'h02, 16'd3, FAULT_CKA, 0);
		send_frame(8'h03, 8'h04, 16'd3, FAULT_CKB, 0);

		// widest limit: fill the whole store and run past it
		wait_drained();
		cfg_write(CFG_UNUSED, 16'hFFFF);
		cfg_write(CFG_LENGTH_LIMIT, 16'hFFFF);
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_frame(8'hA5, 8'h5A, 16'd300, FAULT_NONE, 0);
		send_frame(8'hA5, 8'h5A, 16'hFFFF, FAULT_NONE, 0);
		send_frame(8'h0F, 8'hF0, 16'd1, FAULT_NONE, 0);
		queue_read_at(STORE_DEPTH - 1);
		queue_read_at(128);
		queue_read_at(0);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: reconfigure(8'h00, 8'hFF, 16'h0000);
				1: reconfigure(8'hFF, 8'h00, 16'h0001);
				2: reconfigure(8'($urandom), 8'($urandom), 16'($urandom_range(1, 64)));
				3: begin
					same_sync = 8'($urandom);
					reconfigure(same_sync, same_sync, 16'hFFFF);
				end
				4: reconfigure(SYNC_FIRST_RESET, SYNC_SECOND_RESET, LENGTH_LIMIT_RESET);
				default: reconfigure(8'($urandom), 8'($urandom), 16'($urandom));
			endcase
			send_idle_pct = (p < 2) ? 12 : (p < 4) ? 77 : 0;
			recv_idle_pct = (p < 2) ? 77 : (p < 4) ? 12 : 0;
			phase_goal = queued_count + PHASE_ITEMS;
			while (queued_count < phase_goal)
				send_random_frame();
			// hold the receiver off while the sender keeps going
			if (p == 4)
				stall_requests++;
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
rtl/ufr_pkg.sv
rtl/ufr_ram.sv
rtl/ufr_parser.sv
rtl/ubx_frame_receiver_core.sv
sim/testbench.sv
